### rtl/gear_from_speed_and_rpm_assert.svh
// assertion macros used by the checker file
`ifndef GEAR_FROM_SPEED_AND_RPM_ASSERT_SVH
`define GEAR_FROM_SPEED_AND_RPM_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define GFSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gear_from_speed_and_rpm: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GFSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gear_from_speed_and_rpm: assertion failed");

`endif

### rtl/gfsr_pkg.sv
package gfsr_pkg;

	localparam int MAX_GEARS = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SPEED_W = 16;
	localparam int RPM_W = 14;
	localparam int SCALE_W = 10;
	localparam int P1_W = RPM_W + SCALE_W;
	localparam int DEN_W = 32;
	localparam int NUM_W = 40;
	localparam int Q_W = 16;
	localparam int WIDE_W = DEN_W + Q_W;
	localparam int GEAR_W = 4;

	localparam logic [SPEED_W-1:0] MIN_SPEED = 16'd200;
	localparam logic [RPM_W-1:0] MIN_RPM = 14'd500;
	localparam logic [SCALE_W-1:0] RATIO_SCALE = 10'd600;
	localparam logic [Q_W-1:0] RATIO_MAX = 16'hFFFF;

	localparam logic [CFG_DATA_W-1:0] TYRE_RESET = 16'd19000;
	localparam logic [CFG_DATA_W-1:0] FINAL_DRIVE_RESET = 16'd3900;
	localparam logic [CFG_DATA_W-1:0] GEAR_RESET [MAX_GEARS] = '{
		16'd3321, 16'd1902, 16'd1308, 16'd1000, 16'd759, 16'd600
	};

	localparam logic signed [GEAR_W-1:0] GEAR_UNKNOWN = -4'sd1;
	localparam logic signed [GEAR_W-1:0] GEAR_NEUTRAL = 4'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TYRE_CIRC   = 3'd0,
		REG_FINAL_DRIVE = 3'd1,
		REG_GEAR_FIRST  = 3'd2
	} cfg_reg_t;

	// how a sample is resolved
	typedef enum logic [1:0] {
		CLS_SWITCH,
		CLS_SLOW,
		CLS_RATIO
	} cls_t;

endpackage

### rtl/gfsr_in_if.sv
interface gfsr_in_if;
	logic        valid;
	logic        ready;
	logic        neutral_switch;
	logic        clutch_switch;
	logic [15:0] rear_speed;
	logic [13:0] engine_speed;

	modport source (output valid, neutral_switch, clutch_switch, rear_speed, engine_speed,
		input ready);
	modport sink (input valid, neutral_switch, clutch_switch, rear_speed, engine_speed,
		output ready);
	modport mon (input valid, ready, neutral_switch, clutch_switch, rear_speed, engine_speed);
endinterface

### rtl/gfsr_out_if.sv
interface gfsr_out_if;
	logic               valid;
	logic               ready;
	logic signed [3:0]  gear;
	logic        [15:0] observed_ratio;
	logic        [15:0] match_error;

	modport source (output valid, gear, observed_ratio, match_error, input ready);
	modport sink (input valid, gear, observed_ratio, match_error, output ready);
	modport mon (input valid, ready, gear, observed_ratio, match_error);
endinterface

### rtl/gfsr_cfg_if.sv
interface gfsr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport mon (input valid, ready, index, data);
endinterface

### rtl/gear_from_speed_and_rpm.sv
// gear inference from rear wheel speed and engine speed
// path of a sample word: stage 1, stage 2, divider load, divider chain, error stage, result register
// throughput: one word per cycle while the result side does not stall; the 16-stage restoring divider sets the depth
// a stall on the result side freezes the whole pipeline, nothing is dropped
// reset (arst_n low, asynchronous): pipeline emptied, configuration registers to their defaults
module gear_from_speed_and_rpm #(
	parameter int GEAR_COUNT = 6
) (
	input logic clk,
	input logic arst_n,
	gfsr_in_if.sink samples,
	gfsr_out_if.source results,
	gfsr_cfg_if.sink cfg
);
	import gfsr_pkg::*;

	localparam int DIV_STAGES = Q_W;

	// configuration registers
	logic [CFG_DATA_W-1:0] tyre_q;
	logic [CFG_DATA_W-1:0] final_drive_q;
	logic [CFG_DATA_W-1:0] gear_ratio_q [GEAR_COUNT];

	// one stage of the divider: remainder shrinks, quotient fills from the top
	typedef struct packed {
		cls_t             cls;
		logic             sat;
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [Q_W-1:0]   quot;
	} div_t;

	// pipeline control: everything moves together when the result slot can take a word
	logic adv;

	// stage 1: classify, first products
	logic             vld_s1;
	cls_t             cls_s1;
	logic [P1_W-1:0]  p1_s1;
	logic [DEN_W-1:0] den_s1;
	cls_t             cls_in;

	// stage 2: full numerator
	logic             vld_s2;
	cls_t             cls_s2;
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;

	// stage 3 and the divider chain
	logic [DIV_STAGES:0] div_vld_s;
	div_t                div_s [DIV_STAGES+1];

	// error stage
	logic           vld_s20;
	cls_t           cls_s20;
	logic [Q_W-1:0] ratio_s20;
	logic [Q_W-1:0] err_s20 [GEAR_COUNT];

	// result register
	logic                      res_vld_s21;
	logic signed [GEAR_W-1:0]  res_gear_s21;
	logic        [Q_W-1:0]     res_ratio_s21;
	logic        [Q_W-1:0]     res_err_s21;

	assign adv = !res_vld_s21 || results.ready;
	assign samples.ready = adv;
	assign cfg.ready = 1'b1;

	// ---------------------------------------------------------------
	// configuration writes; indexes past the configured gears are dropped
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tyre_q <= TYRE_RESET;
			final_drive_q <= FINAL_DRIVE_RESET;
			for (int g = 0; g < GEAR_COUNT; g++) begin
				gear_ratio_q[g] <= GEAR_RESET[g];
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TYRE_CIRC: begin
					tyre_q <= cfg.data;
				end
				REG_FINAL_DRIVE: begin
					final_drive_q <= cfg.data;
				end
				default: begin
					for (int g = 0; g < GEAR_COUNT; g++) begin
						if (cfg.index == CFG_IDX_W'(int'(REG_GEAR_FIRST) + g)) begin
							gear_ratio_q[g] <= cfg.data;
						end
					end
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage 1: switches win, then the too-slow check, else compute
	// ---------------------------------------------------------------
	always_comb begin
		if (samples.neutral_switch || samples.clutch_switch) begin
			cls_in = CLS_SWITCH;
		end else if (samples.rear_speed < MIN_SPEED || samples.engine_speed < MIN_RPM) begin
			cls_in = CLS_SLOW;
		end else begin
			cls_in = CLS_RATIO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= samples.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1 <= cls_in;
			// 600 * rpm, and speed * final drive, in parallel
			p1_s1 <= P1_W'(samples.engine_speed) * P1_W'(RATIO_SCALE);
			den_s1 <= DEN_W'(samples.rear_speed) * DEN_W'(final_drive_q);
			// stage 2: numerator 600 * rpm * circumference (24 x 16 bits)
			cls_s2 <= cls_s1;
			num_s2 <= NUM_W'(p1_s1) * NUM_W'(tyre_q);
			den_s2 <= den_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: saturation when the quotient cannot fit 16 bits
	// or the denominator is zero; then load the divider
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].cls <= cls_s2;
			div_s[0].sat <= (den_s2 == '0) || (WIDE_W'(num_s2) >= {den_s2, {Q_W{1'b0}}});
			div_s[0].rem <= num_s2;
			div_s[0].den <= den_s2;
			div_s[0].quot <= '0;
		end
	end

	// ---------------------------------------------------------------
	// restoring divider, one quotient bit per stage, msb first
	// ---------------------------------------------------------------
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		localparam int BIT = Q_W - 1 - j;
		logic [WIDE_W-1:0] den_sh;
		logic              ge;

		assign den_sh = WIDE_W'(div_s[j].den) << BIT;
		assign ge = WIDE_W'(div_s[j].rem) >= den_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				div_vld_s[j+1] <= div_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[j+1].cls <= div_s[j].cls;
				div_s[j+1].sat <= div_s[j].sat;
				div_s[j+1].den <= div_s[j].den;
				div_s[j+1].rem <= ge ? div_s[j].rem - den_sh[NUM_W-1:0] : div_s[j].rem;
				div_s[j+1].quot <= div_s[j].quot | (Q_W'(ge) << BIT);
			end
		end
	end

	// ---------------------------------------------------------------
	// error stage: final ratio and the distance to every gear
	// ---------------------------------------------------------------
	logic [Q_W-1:0] ratio_d;

	assign ratio_d = div_s[DIV_STAGES].sat ? RATIO_MAX : div_s[DIV_STAGES].quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s20 <= 1'b0;
		end else if (adv) begin
			vld_s20 <= div_vld_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s20 <= div_s[DIV_STAGES].cls;
			ratio_s20 <= ratio_d;
			for (int g = 0; g < GEAR_COUNT; g++) begin
				err_s20[g] <= (ratio_d > gear_ratio_q[g]) ? ratio_d - gear_ratio_q[g]
					: gear_ratio_q[g] - ratio_d;
			end
		end
	end

	// ---------------------------------------------------------------
	// result stage: nearest gear, strict less-than keeps the lower gear on a tie
	// ---------------------------------------------------------------
	logic [Q_W-1:0]    best_err;
	logic [GEAR_W-1:0] best_gear;

	always_comb begin
		best_err = err_s20[0];
		best_gear = GEAR_W'(1);
		for (int g = 1; g < GEAR_COUNT; g++) begin
			if (err_s20[g] < best_err) begin
				best_err = err_s20[g];
				best_gear = GEAR_W'(g + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s21 <= 1'b0;
		end else if (adv) begin
			res_vld_s21 <= vld_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (cls_s20)
				CLS_SWITCH: begin
					res_gear_s21 <= GEAR_NEUTRAL;
					res_ratio_s21 <= '0;
					res_err_s21 <= '0;
				end
				CLS_RATIO: begin
					res_gear_s21 <= $signed(best_gear);
					res_ratio_s21 <= ratio_s20;
					res_err_s21 <= best_err;
				end
				default: begin
					res_gear_s21 <= GEAR_UNKNOWN;
					res_ratio_s21 <= '0;
					res_err_s21 <= '0;
				end
			endcase
		end
	end

	assign results.valid = res_vld_s21;
	assign results.gear = res_gear_s21;
	assign results.observed_ratio = res_ratio_s21;
	assign results.match_error = res_err_s21;

endmodule

### rtl/gfsr_checker.sv
`include "gear_from_speed_and_rpm_assert.svh"

module gfsr_checker #(
	parameter int GEAR_COUNT = 6
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [3:0]  gear,
	input logic        [15:0] observed_ratio,
	input logic        [15:0] match_error,
	input logic               cfg_valid,
	input logic               cfg_ready
);
	localparam logic signed [4:0] GEAR_TOP = 5'(GEAR_COUNT);

	// a pending result holds until taken
	`GFSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(gear) && $stable(observed_ratio) && $stable(match_error))

	// gear stays within unknown .. configured gear count
	`GFSR_ASSERT_IMPLY(a_gear_range, clk, arst_n, out_valid, gear >= -5'sd1 && gear <= GEAR_TOP)

	// unknown or neutral results carry no ratio and no error
	`GFSR_ASSERT_IMPLY(a_no_ratio, clk, arst_n, out_valid && gear <= 4'sd0, observed_ratio == 16'd0 && match_error == 16'd0)

	// with nothing waiting at the output, a sample word is always taken
	`GFSR_ASSERT_IMPLY(a_in_ready, clk, arst_n, !out_valid, in_ready)

	// configuration writes never stall
	`GFSR_ASSERT_IMPLY(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind gear_from_speed_and_rpm gfsr_checker #(.GEAR_COUNT(GEAR_COUNT)) u_gfsr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.gear(results.gear),
	.observed_ratio(results.observed_ratio),
	.match_error(results.match_error),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready)
);
